### rtl/shadow_light_slot_table_defines.svh
// Assertion macros for the shadow light slot table.
`ifndef SHADOW_LIGHT_SLOT_TABLE_DEFINES_SVH
`define SHADOW_LIGHT_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slot table check failed");
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slot table check failed");
`else
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/slt_pkg.sv
// Types and constants shared by the shadow light slot table.
package slt_pkg;

	localparam int SHADOW_SLOTS = 8;
	localparam int DIST_W = 32;

	localparam logic [1:0] OUT_UPDATED  = 2'd0;
	localparam logic [1:0] OUT_FREE     = 2'd1;
	localparam logic [1:0] OUT_REPLACED = 2'd2;
	localparam logic [1:0] OUT_NONE     = 2'd3;

	typedef struct packed {
		logic [15:0]        light_key;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic               light_kind;
		logic [15:0]        light_radius;
	} light_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [2:0] slot_index;
	} result_t;

	typedef struct packed {
		logic              vld;
		logic              hit;
		logic              free;
		logic              pick;
		logic [15:0]       key;
		logic [DIST_W-1:0] best;
	} scan_t;

	typedef struct packed {
		logic              en;
		light_t            light;
		logic [DIST_W-1:0] dist_sq;
	} slot_wr_t;

endpackage

### rtl/slt_cell.sv
// One slot of the table: holds a light and updates the passing scan record.
module slt_cell #(
	parameter int IDX_W = 3,
	parameter int IDX   = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slt_pkg::scan_t         scan_in,
	input  logic [IDX_W-1:0]       hit_idx_in,
	input  logic [IDX_W-1:0]       free_idx_in,
	input  logic [IDX_W-1:0]       pick_idx_in,
	output slt_pkg::scan_t         scan_out,
	output logic [IDX_W-1:0]       hit_idx_out,
	output logic [IDX_W-1:0]       free_idx_out,
	output logic [IDX_W-1:0]       pick_idx_out,
	input  slt_pkg::slot_wr_t      wr,
	input  logic [IDX_W-1:0]       wr_idx,
	output logic                   slot_valid
);

	logic                      valid_q;
	slt_pkg::light_t           light_q;
	logic [slt_pkg::DIST_W-1:0] dist_q;
	slt_pkg::scan_t            scan_d;
	slt_pkg::scan_t            scan_q;
	logic [IDX_W-1:0]          hit_idx_d, free_idx_d, pick_idx_d;
	logic [IDX_W-1:0]          hit_idx_q, free_idx_q, pick_idx_q;
	logic                      wr_hit;

	assign wr_hit = wr.en && (wr_idx == IDX_W'(IDX));

	always_comb begin
		scan_d = scan_in;
		hit_idx_d = hit_idx_in;
		free_idx_d = free_idx_in;
		pick_idx_d = pick_idx_in;
		if (scan_in.vld) begin
			if (valid_q && (light_q.light_key == scan_in.key) && !scan_in.hit) begin
				scan_d.hit = 1'b1;
				hit_idx_d = IDX_W'(IDX);
			end
			if (!valid_q && !scan_in.free) begin
				scan_d.free = 1'b1;
				free_idx_d = IDX_W'(IDX);
			end
			if (valid_q && (dist_q >= scan_in.best)) begin
				scan_d.best = dist_q;
				scan_d.pick = 1'b1;
				pick_idx_d = IDX_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
			if (wr_hit) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q <= hit_idx_d;
		free_idx_q <= free_idx_d;
		pick_idx_q <= pick_idx_d;
		if (wr_hit) begin
			light_q <= wr.light;
			dist_q <= wr.dist_sq;
		end
	end

	assign scan_out = scan_q;
	assign hit_idx_out = hit_idx_q;
	assign free_idx_out = free_idx_q;
	assign pick_idx_out = pick_idx_q;
	assign slot_valid = valid_q;

endmodule

### rtl/shadow_light_slot_table.sv
// Shadow light slot table: squared-distance unit, slot chain and writeback control.
// The result is registered after the squared-distance steps, the slot chain walk and the outcome decode.
// A new light is taken only after the previous result has been issued; a scan record walks the slot chain.
// Squared distance uses one 16x16 multiplier, one axis at a time, before the scan starts.
// Reset: arst_n clears all slot valid bits, the sequencer and the result valid flag.
`include "shadow_light_slot_table_defines.svh"
module shadow_light_slot_table #(
	parameter int SHADOW_SLOTS = slt_pkg::SHADOW_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              light_valid,
	output logic              light_ready,
	input  slt_pkg::light_t   light,
	output logic              result_valid,
	input  logic              result_ready,
	output slt_pkg::result_t  result
);

	localparam int IDX_W = (SHADOW_SLOTS > 1) ? $clog2(SHADOW_SLOTS) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ     = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                 state_q;
	logic [1:0]                 cnt_q;
	slt_pkg::light_t            item_q;
	logic [15:0]                axis;
	logic [15:0]                mag;
	logic [slt_pkg::DIST_W-1:0] prod_q;
	logic [slt_pkg::DIST_W-1:0] acc_q;

	slt_pkg::scan_t             chain [SHADOW_SLOTS+1];
	logic [IDX_W-1:0]           hit_idx [SHADOW_SLOTS+1];
	logic [IDX_W-1:0]           free_idx [SHADOW_SLOTS+1];
	logic [IDX_W-1:0]           pick_idx [SHADOW_SLOTS+1];
	logic [SHADOW_SLOTS-1:0]    tok_vec;
	logic [SHADOW_SLOTS-1:0]    valid_vec;

	logic [1:0]                 dec_outcome_d, dec_outcome_q;
	logic [IDX_W-1:0]           dec_idx_d, dec_idx_q;
	logic                       dec_wr_q;
	logic [IDX_W+2:0]           idx_ext;
	logic                       done_go;
	slt_pkg::slot_wr_t          wr;
	logic                       result_valid_q;
	slt_pkg::result_t           result_q;
	slt_pkg::scan_t             tail;

	assign light_ready = (state_q == ST_IDLE);
	assign done_go = (state_q == ST_DONE) && (!result_valid_q || result_ready);

	always_comb begin
		case (cnt_q)
			2'd0: axis = item_q.pos_x;
			2'd1: axis = item_q.pos_y;
			default: axis = item_q.pos_z;
		endcase
		mag = axis[15] ? (~axis + 16'd1) : axis;
	end

	assign chain[0] = '{vld: (state_q == ST_LAUNCH), hit: 1'b0, free: 1'b0, pick: 1'b0,
		key: item_q.light_key, best: acc_q};
	assign hit_idx[0] = '0;
	assign free_idx[0] = '0;
	assign pick_idx[0] = '0;

	for (genvar i = 0; i < SHADOW_SLOTS; i++) begin : g_cell
		slt_cell #(
			.IDX_W(IDX_W),
			.IDX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.scan_in     (chain[i]),
			.hit_idx_in  (hit_idx[i]),
			.free_idx_in (free_idx[i]),
			.pick_idx_in (pick_idx[i]),
			.scan_out    (chain[i+1]),
			.hit_idx_out (hit_idx[i+1]),
			.free_idx_out(free_idx[i+1]),
			.pick_idx_out(pick_idx[i+1]),
			.wr          (wr),
			.wr_idx      (dec_idx_q),
			.slot_valid  (valid_vec[i])
		);
		assign tok_vec[i] = chain[i+1].vld;
	end

	assign tail = chain[SHADOW_SLOTS];

	always_comb begin
		if (tail.hit) begin
			dec_outcome_d = slt_pkg::OUT_UPDATED;
			dec_idx_d = hit_idx[SHADOW_SLOTS];
		end else if (tail.free) begin
			dec_outcome_d = slt_pkg::OUT_FREE;
			dec_idx_d = free_idx[SHADOW_SLOTS];
		end else if (tail.pick) begin
			dec_outcome_d = slt_pkg::OUT_REPLACED;
			dec_idx_d = pick_idx[SHADOW_SLOTS];
		end else begin
			dec_outcome_d = slt_pkg::OUT_NONE;
			dec_idx_d = '0;
		end
	end

	assign wr = '{en: done_go && dec_wr_q, light: item_q, dist_sq: acc_q};
	assign idx_ext = {3'b000, dec_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			dec_wr_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (light_valid) begin
						cnt_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (tail.vld) begin
						dec_wr_q <= (dec_outcome_d != slt_pkg::OUT_NONE);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (done_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (light_valid && light_ready) begin
			item_q <= light;
			acc_q <= '0;
		end else if (state_q == ST_SQ) begin
			prod_q <= 32'(mag) * 32'(mag);
			if (cnt_q != 2'd0) begin
				acc_q <= acc_q + prod_q;
			end
		end
		if ((state_q == ST_WAIT) && tail.vld) begin
			dec_outcome_q <= dec_outcome_d;
			dec_idx_q <= dec_idx_d;
		end
		if (done_go) begin
			result_q.outcome <= dec_outcome_q;
			result_q.slot_index <= idx_ext[2:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`SLT_ASSERT_IMP(a_idle_chain_empty, clk, arst_n, state_q == ST_IDLE, tok_vec == '0)
	`SLT_ASSERT_IMP(a_one_scan, clk, arst_n, 1'b1, $onehot0(tok_vec))
	`SLT_ASSERT_NXT(a_write_sets_valid, clk, arst_n, wr.en, valid_vec[dec_idx_q])
	`SLT_ASSERT_IMP(a_none_index_zero, clk, arst_n,
		result_valid && (result.outcome == slt_pkg::OUT_NONE), result.slot_index == 3'd0)

endmodule
